[rtl/core/swsfr_pkg.sv]
`default_nettype none
package swsfr_pkg;

	localparam int WINDOW_SIZE_DEF  = 4;
	localparam int SEQ_SPACE_DEF    = 8;
	localparam int PAYLOAD_BITS_DEF = 64;

	// status included; other results beyond MAX_RESULTS-1 are dropped
	localparam int MAX_RESULTS = 11;

	localparam logic [1:0] CMD_SEND    = 2'd0;
	localparam logic [1:0] CMD_ACK     = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	localparam logic [1:0] ACT_TX     = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_STOP   = 2'd2;
	localparam logic [1:0] ACT_STATUS = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] payload_word;
		logic [2:0]  ack_number;
		logic        ack_intact;
	} item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  sequence_res;
		logic [63:0] packet_data;
		logic        accepted;
		logic        window_waiting;
		logic        final_item;
	} result_t;

endpackage
`default_nettype wire

[rtl/core/swsfr_ring.sv]
`default_nettype none
module swsfr_ring
	import swsfr_pkg::*;
#(
	parameter int DEPTH  = WINDOW_SIZE_DEF,
	parameter int WIDTH  = PAYLOAD_BITS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[rtl/core/sliding_window_sender_fast_retransmit.sv]
`default_nettype none
// Results leave through a registered result port. An item gives N non-status results
// (0 to 10 at default sizes) and then one status word, and keeps busy high until the
// status word is out. Throughput is set by the single result port: one result word per
// cycle. The receiver cannot stall the block.
// Reset (arst_n low) empties the window and loads the ack history with invalid marks;
// payload ring entries are undefined until written.
module sliding_window_sender_fast_retransmit
	import swsfr_pkg::*;
#(
	parameter int WINDOW_SIZE  = WINDOW_SIZE_DEF,
	parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    result_valid,
	output result_t result
);

	localparam int SEQ_W  = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
	localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
	localparam int RING_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int HIST_W = ($clog2(SEQ_SPACE + 3) > 3) ? $clog2(SEQ_SPACE + 3) : 3;
	localparam int M1     = (SEQ_W > CNT_W) ? SEQ_W : CNT_W;
	localparam int D_W    = ((M1 > 3) ? M1 : 3) + 1;
	localparam int EMIT_W = $clog2(MAX_RESULTS);

	localparam logic [SEQ_W-1:0]  SEQ_LAST  = SEQ_W'(SEQ_SPACE - 1);
	localparam logic [RING_W-1:0] RING_LAST = RING_W'(WINDOW_SIZE - 1);
	localparam logic [CNT_W-1:0]  WIN_FULL  = CNT_W'(WINDOW_SIZE);
	localparam logic [EMIT_W-1:0] EMIT_CAP  = EMIT_W'(MAX_RESULTS - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_SEND_TX, ST_FR_STOP, ST_FR_START, ST_FR_TX,
		ST_FREE, ST_RE_STOP, ST_RE_START, ST_STATUS
	} state_t;

	state_t                  state_q;
	logic [1:0]              cmd_q;
	logic [PAYLOAD_BITS-1:0] word_q;
	logic [2:0]              ack_q;
	logic                    intact_q;
	logic [SEQ_W-1:0]        base_q;
	logic [SEQ_W-1:0]        next_q;
	logic [CNT_W-1:0]        count_q;
	logic                    waiting_q;
	logic [HIST_W-1:0]       hist_q [3];
	logic [1:0]              hctr_q;
	logic [RING_W-1:0]       head_q;
	logic                    accepted_q;
	logic                    slide_q;
	logic [CNT_W-1:0]        left_q;
	logic [SEQ_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        rem_q;
	logic [EMIT_W-1:0]       emit_q;
	logic                    result_valid_q;
	result_t                 result_q;

	logic [HIST_W-1:0]       ack_h;
	logic [HIST_W-1:0]       hist_new [3];
	logic                    fast;
	logic [D_W-1:0]          ack_d;
	logic [D_W-1:0]          base_d;
	logic [D_W-1:0]          ack_off;
	logic                    slide;
	logic                    send_ok;
	logic [RING_W:0]         wr_sum;
	logic [RING_W:0]         wr_idx;
	logic [PAYLOAD_BITS-1:0] rd_data;
	logic [PAYLOAD_BITS+63:0] tx_wide;
	logic [PAYLOAD_BITS-1:0] tx_data;
	logic                    ring_we;
	logic                    ring_re;
	logic                    emit_want;
	logic                    emit_take;
	result_t                 emit_res;

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
		return (s == SEQ_LAST) ? '0 : s + SEQ_W'(1);
	endfunction

	function automatic logic [2:0] seq3(input logic [SEQ_W-1:0] s);
		logic [SEQ_W+2:0] w;
		w = {3'b000, s};
		return w[2:0];
	endfunction

	assign busy = (state_q != ST_IDLE);

	// history as it stands after this ack is written
	assign ack_h = HIST_W'(ack_q);
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			hist_new[j] = (hctr_q == 2'(j)) ? ack_h : hist_q[j];
		end
	end
	assign fast = (hist_new[0] == hist_new[1]) && (hist_new[1] == hist_new[2]) &&
	              (count_q != '0);

	assign ack_d   = D_W'(ack_q);
	assign base_d  = D_W'(base_q);
	assign ack_off = (ack_d >= base_d) ? ack_d - base_d : ack_d + D_W'(SEQ_SPACE) - base_d;
	assign slide   = (ack_d < D_W'(SEQ_SPACE)) && (ack_off < D_W'(count_q));

	assign send_ok = !waiting_q && (count_q < WIN_FULL);
	assign wr_sum  = (RING_W+1)'(head_q) + (RING_W+1)'(count_q);
	assign wr_idx  = (wr_sum >= (RING_W+1)'(WINDOW_SIZE)) ?
	                 wr_sum - (RING_W+1)'(WINDOW_SIZE) : wr_sum;

	assign ring_we = (state_q == ST_DECODE) && (cmd_q == CMD_SEND) && send_ok;
	assign ring_re = (state_q == ST_FR_STOP);

	swsfr_ring #(
		.DEPTH (WINDOW_SIZE),
		.WIDTH (PAYLOAD_BITS),
		.ADDR_W(RING_W)
	) u_ring (
		.clk    (clk),
		.wr_en  (ring_we),
		.wr_addr(wr_idx[RING_W-1:0]),
		.wr_data(word_q),
		.rd_en  (ring_re),
		.rd_addr(head_q),
		.rd_data(rd_data)
	);

	assign tx_data = (state_q == ST_FR_TX) ? rd_data : word_q;
	assign tx_wide = {64'd0, tx_data};

	always_comb begin
		emit_want = 1'b0;
		emit_res  = '0;
		unique case (state_q)
			ST_DECODE: begin
				if (cmd_q == CMD_SEND && send_ok && count_q == '0) begin
					emit_want             = 1'b1;
					emit_res.action       = ACT_START;
					emit_res.sequence_res = seq3(next_q);
				end
			end
			ST_SEND_TX: begin
				emit_want             = 1'b1;
				emit_res.action       = ACT_TX;
				emit_res.sequence_res = seq3(next_q);
				emit_res.packet_data  = tx_wide[63:0];
			end
			ST_FR_STOP, ST_FREE: begin
				emit_want             = 1'b1;
				emit_res.action       = ACT_STOP;
				emit_res.sequence_res = seq3(base_q);
			end
			ST_FR_START: begin
				emit_want             = 1'b1;
				emit_res.action       = ACT_START;
				emit_res.sequence_res = seq3(base_q);
			end
			ST_FR_TX: begin
				emit_want             = 1'b1;
				emit_res.action       = ACT_TX;
				emit_res.sequence_res = seq3(base_q);
				emit_res.packet_data  = tx_wide[63:0];
			end
			ST_RE_STOP: begin
				emit_want             = 1'b1;
				emit_res.action       = ACT_STOP;
				emit_res.sequence_res = seq3(ptr_q);
			end
			ST_RE_START: begin
				emit_want             = 1'b1;
				emit_res.action       = ACT_START;
				emit_res.sequence_res = seq3(ptr_q);
			end
			ST_STATUS: begin
				emit_want               = 1'b1;
				emit_res.action         = ACT_STATUS;
				emit_res.accepted       = accepted_q;
				emit_res.window_waiting = waiting_q;
				emit_res.final_item     = 1'b1;
			end
			default: begin
				emit_want = 1'b0;
			end
		endcase
	end

	// drop non-status words once the per-item budget is spent
	assign emit_take = emit_want && (emit_res.final_item || emit_q < EMIT_CAP);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			word_q <= item.payload_word[PAYLOAD_BITS-1:0];
		end
		result_q <= emit_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cmd_q          <= CMD_SEND;
			ack_q          <= '0;
			intact_q       <= 1'b0;
			base_q         <= '0;
			next_q         <= '0;
			count_q        <= '0;
			waiting_q      <= 1'b0;
			hist_q[0]      <= HIST_W'(SEQ_SPACE);
			hist_q[1]      <= HIST_W'(SEQ_SPACE + 1);
			hist_q[2]      <= HIST_W'(SEQ_SPACE + 2);
			hctr_q         <= '0;
			head_q         <= '0;
			accepted_q     <= 1'b0;
			slide_q        <= 1'b0;
			left_q         <= '0;
			ptr_q          <= '0;
			rem_q          <= '0;
			emit_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit_take;
			if (emit_take && !emit_res.final_item) begin
				emit_q <= emit_q + EMIT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q      <= item.cmd;
						ack_q      <= item.ack_number;
						intact_q   <= item.ack_intact;
						accepted_q <= 1'b0;
						slide_q    <= 1'b0;
						emit_q     <= '0;
						state_q    <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					unique case (cmd_q)
						CMD_SEND: begin
							if (waiting_q) begin
								state_q <= ST_STATUS;
							end else if (send_ok) begin
								state_q <= ST_SEND_TX;
							end else begin
								waiting_q <= 1'b1;
								state_q   <= ST_STATUS;
							end
						end
						CMD_ACK: begin
							if (intact_q) begin
								for (int j = 0; j < 3; j++) begin
									hist_q[j] <= hist_new[j];
								end
								hctr_q  <= (hctr_q == 2'd2) ? 2'd0 : hctr_q + 2'd1;
								slide_q <= slide;
								left_q  <= CNT_W'(ack_off + D_W'(1));
								if (fast) begin
									state_q <= ST_FR_STOP;
								end else if (slide) begin
									state_q <= ST_FREE;
								end else begin
									state_q <= ST_STATUS;
								end
							end else begin
								state_q <= ST_STATUS;
							end
						end
						CMD_TIMEOUT: begin
							state_q <= (count_q != '0) ? ST_FR_STOP : ST_STATUS;
						end
						default: begin
							state_q <= ST_STATUS;
						end
					endcase
				end
				ST_SEND_TX: begin
					next_q     <= seq_inc(next_q);
					count_q    <= count_q + CNT_W'(1);
					waiting_q  <= (count_q + CNT_W'(1) == WIN_FULL);
					accepted_q <= 1'b1;
					state_q    <= ST_STATUS;
				end
				ST_FR_STOP: begin
					state_q <= ST_FR_START;
				end
				ST_FR_START: begin
					state_q <= ST_FR_TX;
				end
				ST_FR_TX: begin
					state_q <= slide_q ? ST_FREE : ST_STATUS;
				end
				ST_FREE: begin
					// advance the window one packet per cycle
					base_q    <= seq_inc(base_q);
					head_q    <= (head_q == RING_LAST) ? '0 : head_q + RING_W'(1);
					count_q   <= count_q - CNT_W'(1);
					left_q    <= left_q - CNT_W'(1);
					waiting_q <= 1'b0;
					if (left_q == CNT_W'(1)) begin
						ptr_q   <= seq_inc(base_q);
						rem_q   <= count_q - CNT_W'(1);
						state_q <= (count_q != CNT_W'(1)) ? ST_RE_STOP : ST_STATUS;
					end
				end
				ST_RE_STOP: begin
					state_q <= ST_RE_START;
				end
				ST_RE_START: begin
					ptr_q   <= seq_inc(ptr_q);
					rem_q   <= rem_q - CNT_W'(1);
					state_q <= (rem_q == CNT_W'(1)) ? ST_STATUS : ST_RE_STOP;
				end
				ST_STATUS: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_final_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.final_item |-> !busy)
		else $error("status word while still busy");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= WIN_FULL)
		else $error("outstanding count beyond window");

	a_full_waits: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == WIN_FULL |-> waiting_q)
		else $error("full window without waiting flag");
`endif

endmodule
`default_nettype wire

[sim/swsfr_checker.sv]
`timescale 1ns / 100ps
module swsfr_checker
	import swsfr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    result_valid,
	input  result_t result,
	output int      status_count,
	output int      fault_count
);

	localparam int WIN = WINDOW_SIZE_DEF;
	localparam int SEQ = SEQ_SPACE_DEF;

	int          win_base;
	int          next_seq;
	int          in_flight;
	int          ring_head;
	int          hist_slot;
	bit          waiting;
	int          ack_hist [3];
	logic [63:0] payload_ring [WIN];
	int          words_this_item;
	int          mismatch_count;
	result_t     expected_words [$];

	function automatic void clear_sender();
		win_base = 0;
		next_seq = 0;
		in_flight = 0;
		ring_head = 0;
		hist_slot = 0;
		waiting = 1'b0;
		// marks that no 3-bit ack can match
		ack_hist[0] = SEQ;
		ack_hist[1] = SEQ + 1;
		ack_hist[2] = SEQ + 2;
		for (int i = 0; i < WIN; i++)
			payload_ring[i] = '0;
	endfunction

	function automatic void emit(logic [1:0] act, int seq, logic [63:0] data, bit acc, bit fin);
		result_t r;
		// drop non-status words past the port budget so the status still fits
		if (!fin && words_this_item >= MAX_RESULTS - 1)
			return;
		r.action         = act;
		r.sequence_res   = seq[2:0];
		r.packet_data    = data;
		r.accepted       = fin ? acc : 1'b0;
		r.window_waiting = fin ? waiting : 1'b0;
		r.final_item     = fin;
		expected_words.push_back(r);
		words_this_item++;
	endfunction

	function automatic void resend_oldest();
		emit(ACT_STOP, win_base, '0, 1'b0, 1'b0);
		emit(ACT_START, win_base, '0, 1'b0, 1'b0);
		emit(ACT_TX, win_base, payload_ring[ring_head % WIN], 1'b0, 1'b0);
	endfunction

	function automatic void predict_words(item_t w);
		bit taken;
		int gap;
		int freed;
		taken = 1'b0;
		words_this_item = 0;
		case (w.cmd)
			CMD_SEND: begin
				if (!waiting) begin
					if (in_flight < WIN) begin
						payload_ring[(ring_head + in_flight) % WIN] = w.payload_word;
						if (in_flight == 0)
							emit(ACT_START, next_seq, '0, 1'b0, 1'b0);
						emit(ACT_TX, next_seq, w.payload_word, 1'b0, 1'b0);
						next_seq = (next_seq + 1) % SEQ;
						in_flight++;
						waiting = (in_flight == WIN);
						taken = 1'b1;
					end else begin
						waiting = 1'b1;
					end
				end
			end
			CMD_ACK: begin
				if (w.ack_intact) begin
					ack_hist[hist_slot] = int'(w.ack_number);
					hist_slot = (hist_slot + 1) % 3;
					if (ack_hist[0] == ack_hist[1] && ack_hist[1] == ack_hist[2] && in_flight > 0)
						resend_oldest();
					if (int'(w.ack_number) < SEQ) begin
						gap = (int'(w.ack_number) + SEQ - win_base) % SEQ;
						if (gap < in_flight) begin
							freed = gap + 1;
							for (int i = 0; i < freed; i++)
								emit(ACT_STOP, (win_base + i) % SEQ, '0, 1'b0, 1'b0);
							win_base = (win_base + freed) % SEQ;
							ring_head = (ring_head + freed) % WIN;
							in_flight -= freed;
							// restart every timer still running
							for (int i = 0; i < in_flight; i++) begin
								emit(ACT_STOP, (win_base + i) % SEQ, '0, 1'b0, 1'b0);
								emit(ACT_START, (win_base + i) % SEQ, '0, 1'b0, 1'b0);
							end
							waiting = 1'b0;
						end
					end
				end
			end
			CMD_TIMEOUT: begin
				if (in_flight > 0)
					resend_oldest();
			end
			default: begin
			end
		endcase
		emit(ACT_STATUS, 0, '0, taken, 1'b1);
	endfunction

	task automatic check_word(result_t got);
		result_t want;
		if (expected_words.size() == 0) begin
			if (mismatch_count < 10)
				$display("%0t: unexpected result word act=%0d seq=%0d data=%h acc=%b wait=%b fin=%b",
					$realtime, got.action, got.sequence_res, got.packet_data, got.accepted,
					got.window_waiting, got.final_item);
			mismatch_count++;
		end else begin
			want = expected_words.pop_front();
			if (got.action !== want.action || got.sequence_res !== want.sequence_res ||
				got.packet_data !== want.packet_data || got.accepted !== want.accepted ||
				got.window_waiting !== want.window_waiting ||
				got.final_item !== want.final_item) begin
				if (mismatch_count < 10) begin
					$display("%0t: mismatch expected act=%0d seq=%0d data=%h acc=%b wait=%b fin=%b",
						$realtime, want.action, want.sequence_res, want.packet_data,
						want.accepted, want.window_waiting, want.final_item);
					$display("%0t:          actual   act=%0d seq=%0d data=%h acc=%b wait=%b fin=%b",
						$realtime, got.action, got.sequence_res, got.packet_data,
						got.accepted, got.window_waiting, got.final_item);
				end
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sender();
			expected_words.delete();
			mismatch_count = 0;
			status_count <= 0;
			fault_count <= 0;
		end else begin
			if (result_valid) begin
				check_word(result);
				if (result.final_item)
					status_count <= status_count + 1;
			end
			if (start && !busy)
				predict_words(item);
			// words still owed count against the run once it has drained
			fault_count <= mismatch_count + expected_words.size();
		end
	end

endmodule

[sim/sliding_window_sender_fast_retransmit_test.sv]
`timescale 1ns / 100ps
module sliding_window_sender_fast_retransmit_test;
	import swsfr_pkg::*;

	localparam int         RANDOM_ITEMS = 160;
	localparam int         CYCLE_LIMIT  = 100000;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    result_valid;
	result_t result;

	int         status_count;
	int         fault_count;
	int         issued;
	int         cycles;
	logic [2:0] last_tx_seq;
	logic [2:0] prev_ack;

	sliding_window_sender_fast_retransmit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	swsfr_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.status_count (status_count),
		.fault_count  (fault_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// track the newest transmitted sequence so acks land in the window often
	always @(posedge clk) begin
		if (result_valid && result.action == ACT_TX)
			last_tx_seq <= result.sequence_res;
	end

	function automatic item_t mk_send(logic [63:0] data);
		item_t w;
		w.cmd = CMD_SEND;
		w.payload_word = data;
		w.ack_number = '0;
		w.ack_intact = 1'b0;
		return w;
	endfunction

	function automatic item_t mk_ack(logic [2:0] num, logic intact);
		item_t w;
		w.cmd = CMD_ACK;
		w.payload_word = '0;
		w.ack_number = num;
		w.ack_intact = intact;
		return w;
	endfunction

	function automatic item_t mk_op(logic [1:0] op);
		item_t w;
		w.cmd = op;
		w.payload_word = '1;
		w.ack_number = '1;
		w.ack_intact = 1'b1;
		return w;
	endfunction

	function automatic item_t pick_item();
		item_t w;
		int roll;
		w.payload_word = {$urandom, $urandom};
		w.ack_number = 3'($urandom_range(0, 7));
		w.ack_intact = 1'b1;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			w.cmd = CMD_SEND;
			if ($urandom_range(0, 9) == 0)
				w.payload_word = $urandom_range(0, 1) ? '1 : '0;
		end else if (roll < 88) begin
			w.cmd = CMD_ACK;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: w.ack_number = prev_ack;
				4, 5, 6, 7: w.ack_number = last_tx_seq - 3'($urandom_range(0, 3));
				default: begin
				end
			endcase
			w.ack_intact = ($urandom_range(0, 6) != 0);
			prev_ack = w.ack_number;
		end else if (roll < 98) begin
			w.cmd = CMD_TIMEOUT;
		end else begin
			w.cmd = CMD_UNUSED;
		end
		return w;
	endfunction

	// hold start and the word until the block takes it
	task automatic send_word(item_t w);
		start <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (busy);
		issued++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (status_count != issued)
			@(posedge clk);
	endtask

	initial begin
		int burst;
		int gap;
		int random_sent;
		bit drained_once;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cycles = 0;
		issued = 0;
		last_tx_seq = '0;
		prev_ack = '0;
		random_sent = 0;
		drained_once = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty window: timeout, unused command, equal history with nothing outstanding
		send_word(mk_op(CMD_TIMEOUT));
		send_word(mk_op(CMD_UNUSED));
		send_word(mk_ack(3'd5, 1'b1));
		send_word(mk_ack(3'd5, 1'b1));
		send_word(mk_ack(3'd5, 1'b1));
		send_word(mk_ack(3'd0, 1'b0));
		// fill the window, then send while waiting
		send_word(mk_send(64'h0));
		send_word(mk_send('1));
		send_word(mk_send(64'hAAAA_AAAA_AAAA_AAAA));
		send_word(mk_send(64'h5555_5555_5555_5555));
		send_word(mk_send(64'h1234_5678_9ABC_DEF0));
		send_word(mk_op(CMD_TIMEOUT));
		// out-of-window duplicates trigger fast retransmit on the third
		send_word(mk_ack(3'd7, 1'b1));
		send_word(mk_ack(3'd7, 1'b1));
		send_word(mk_ack(3'd7, 1'b1));
		send_word(mk_ack(3'd0, 1'b1));
		send_word(mk_ack(3'd3, 1'b0));
		send_word(mk_ack(3'd3, 1'b1));
		send_word(mk_send(64'hDEAD_BEEF_0000_0000));
		send_word(mk_ack(3'd2, 1'b1));
		send_word(mk_ack(3'd4, 1'b1));
		wait_drained();

		while (random_sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && random_sent < RANDOM_ITEMS; k++) begin
				send_word(pick_item());
				random_sent++;
			end
			if (!drained_once && random_sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				drained_once = 1'b1;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				// lower start only when a gap follows, never within one step
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		wait_drained();
		repeat (24) @(posedge clk);
		if (fault_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
